/* hdl/sbmm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbmm_pkg: shared types and constants of the sub bus memory map
// Bus item and result types, the decoded operation passed from the front end
// to the back end, region codes, register indexes and the address map.
// ----------------------------------------------------------------------------
package sbmm_pkg;

  // Address map (24-bit byte addresses)
  localparam logic [23:0] PROG_LAST    = 24'h07ffff;
  localparam logic [23:0] WRAM_FIRST   = 24'h080000;
  localparam logic [23:0] WRAM_LAST    = 24'h0bffff;
  localparam logic [23:0] BANK_FIRST   = 24'h0c0000;
  localparam logic [23:0] BANK_LAST    = 24'h0dffff;
  localparam logic [23:0] DISC_FIRST   = 24'hfd0000;
  localparam logic [23:0] BACKUP_FIRST = 24'hfe0000;
  localparam logic [23:0] PCM_FIRST    = 24'hff0000;
  localparam logic [23:0] PCM_LAST     = 24'hff7fff;
  localparam logic [23:0] IO_FIRST     = 24'hff8000;
  // Protect bound granularity: 512-byte units
  localparam int unsigned PROTECT_SHIFT = 9;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned IDX_W      = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROTECT_BOUND = 3'd0,
    CFG_WRAM_SPLIT    = 3'd1,
    CFG_WRAM_GRANTED  = 3'd2,
    CFG_BANK_SELECT   = 3'd3,
    CFG_DOT_PRIORITY  = 3'd4,
    CFG_DISC_PRESENT  = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    RG_PROGRAM = 3'd0,
    RG_WORD    = 3'd1,
    RG_DISC    = 3'd2,
    RG_BACKUP  = 3'd3,
    RG_PCM     = 3'd4,
    RG_IO      = 3'd5,
    RG_NONE    = 3'd6
  } region_e;

  typedef enum logic [1:0] {
    PRIO_NORMAL = 2'd0,
    PRIO_UNDER  = 2'd1,
    PRIO_OVER   = 2'd2,
    PRIO_NONE   = 2'd3
  } dot_prio_e;

  typedef enum logic [1:0] {
    MEM_NONE = 2'd0,
    MEM_PROG = 2'd1,
    MEM_WORD = 2'd2
  } mem_sel_e;

  typedef enum logic {
    BK_ISSUE = 1'b0,
    BK_EXEC  = 1'b1
  } back_state_e;

  typedef struct packed {
    logic        mode;
    logic        upper_strobe;
    logic        lower_strobe;
    logic [23:0] address;
    logic [15:0] data_in;
  } req_t;

  typedef struct packed {
    logic [15:0] read_data;
    region_e     region;
    logic        forwarded;
    logic [23:0] forward_address;
    logic        stalled;
  } rsp_t;

  // Decoded item, as classified by the front end
  typedef struct packed {
    mem_sel_e         mem;
    logic             dot;
    logic             wr;
    logic             up;
    logic             lo;
    logic             a1;
    logic [15:0]      data;
    logic [IDX_W-1:0] idx;
    dot_prio_e        prio;
    region_e          region;
    logic             fwd;
    logic [23:0]      faddr;
    logic             stall;
  } op_t;

endpackage
`default_nettype wire

/* hdl/sbmm_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbmm_front: configuration registers and address decode
// Holds the mode registers, classifies each accepted bus item by region and
// memory target, and pushes the decoded operation into the queue.
// ----------------------------------------------------------------------------
module sbmm_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [sbmm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sbmm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire sbmm_pkg::req_t                 req_i,
  output sbmm_pkg::op_t                       op_o
);
  import sbmm_pkg::*;

  logic [7:0] bound_q;
  logic       split_q;
  logic       granted_q;
  logic       bank_q;
  dot_prio_e  prio_q;
  logic       disc_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q   <= '0;
      split_q   <= 1'b0;
      granted_q <= 1'b0;
      bank_q    <= 1'b0;
      prio_q    <= PRIO_NORMAL;
      disc_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PROTECT_BOUND: bound_q   <= cfg_data_i;
        CFG_WRAM_SPLIT:    split_q   <= cfg_data_i[0];
        CFG_WRAM_GRANTED:  granted_q <= cfg_data_i[0];
        CFG_BANK_SELECT:   bank_q    <= cfg_data_i[0];
        CFG_DOT_PRIORITY:  prio_q    <= dot_prio_e'(cfg_data_i[1:0]);
        CFG_DISC_PRESENT:  disc_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [23:0] addr;
  logic [23:0] protect_limit;
  logic        sel_bit;

  assign addr          = req_i.address;
  assign protect_limit = 24'(bound_q) << PROTECT_SHIFT;
  // Inverted bank select forms word index bit 0 in split mode
  assign sel_bit       = ~bank_q;

  // Classify the item
  always_comb begin
    op_o        = '0;
    op_o.mem    = MEM_NONE;
    op_o.wr     = req_i.mode;
    op_o.up     = req_i.upper_strobe;
    op_o.lo     = req_i.lower_strobe;
    op_o.a1     = addr[1];
    op_o.data   = req_i.data_in;
    op_o.prio   = prio_q;
    op_o.region = RG_NONE;
    priority if (addr <= PROG_LAST) begin
      op_o.region = RG_PROGRAM;
      op_o.idx    = addr[18:1];
      // Drop writes below the protect bound
      op_o.mem    = (req_i.mode && (addr < protect_limit)) ? MEM_NONE : MEM_PROG;
    end else if (addr >= WRAM_FIRST && addr <= WRAM_LAST) begin
      op_o.region = RG_WORD;
      if (!split_q) begin
        op_o.idx = {1'b0, addr[17:1]};
        if (granted_q) begin
          op_o.mem = MEM_WORD;
        end else begin
          op_o.stall = req_i.mode;
        end
      end else begin
        op_o.idx = {1'b0, addr[17:2], sel_bit};
        op_o.mem = MEM_WORD;
        op_o.dot = 1'b1;
      end
    end else if (addr >= BANK_FIRST && addr <= BANK_LAST) begin
      if (split_q) begin
        op_o.region = RG_WORD;
        op_o.idx    = {1'b0, addr[16:1], sel_bit};
        op_o.mem    = MEM_WORD;
      end
    end else if (addr >= DISC_FIRST && addr < BACKUP_FIRST) begin
      if (disc_q) begin
        op_o.region = RG_DISC;
        op_o.fwd    = req_i.lower_strobe;
        op_o.faddr  = req_i.lower_strobe ? {addr[23:1], 1'b1} : '0;
      end
    end else if (addr >= BACKUP_FIRST && addr < PCM_FIRST) begin
      op_o.region = RG_BACKUP;
      op_o.fwd    = req_i.lower_strobe;
      op_o.faddr  = req_i.lower_strobe ? {1'b0, addr[23:1]} : '0;
    end else if (addr >= PCM_FIRST && addr <= PCM_LAST) begin
      op_o.region = RG_PCM;
      op_o.fwd    = req_i.lower_strobe;
      op_o.faddr  = req_i.lower_strobe ? {1'b0, addr[23:1]} : '0;
    end else if (addr >= IO_FIRST) begin
      op_o.region = RG_IO;
      op_o.fwd    = 1'b1;
      op_o.faddr  = addr;
    end else begin
      // Leave unmapped items as region none
      op_o.region = RG_NONE;
    end
  end

endmodule
`default_nettype wire

/* hdl/sbmm_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbmm_queue: two-entry queue of decoded operations
// Decouples the front end from the back end so each can stall on its own.
// ----------------------------------------------------------------------------
module sbmm_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire sbmm_pkg::op_t push_op_i,
  input  wire logic          pop_i,
  output sbmm_pkg::op_t      head_o,
  output logic               full_o,
  output logic               empty_o
);
  import sbmm_pkg::*;

  op_t        slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign head_o  = slot_q[rd_ptr_q];
  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Store pushed item
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_op_i;
  end

endmodule
`default_nettype wire

/* hdl/sbmm_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbmm_back: memory access engine
// Pops one operation and reads program RAM or word RAM in the issue state,
// then forms the result and writes back lanes or dot nibbles in the exec state.
// ----------------------------------------------------------------------------
module sbmm_back #(
  parameter int unsigned PROGRAM_WORDS  = 262144,
  parameter int unsigned WORD_RAM_WORDS = 131072
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire sbmm_pkg::op_t head_i,
  input  wire logic          empty_i,
  output logic               pop_o,
  output logic               done_o,
  output sbmm_pkg::rsp_t     rsp_o
);
  import sbmm_pkg::*;

  localparam int unsigned PROG_AW = $clog2(PROGRAM_WORDS);
  localparam int unsigned WRAM_AW = $clog2(WORD_RAM_WORDS);

  logic [15:0] prog_mem [PROGRAM_WORDS];
  logic [15:0] word_mem [WORD_RAM_WORDS];

  back_state_e state_q, state_d;
  logic        exec;
  op_t         op_q;
  logic [15:0] prog_rdata_q;
  logic [15:0] word_rdata_q;
  logic [1:0]  prog_be;
  logic [3:0]  word_ne;
  logic [3:0]  dot_en;
  logic [15:0] dot_wdata;
  logic [15:0] word_wdata;
  rsp_t        rsp_d;
  logic        done_q;
  rsp_t        rsp_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_ISSUE: if (!empty_i) state_d = BK_EXEC;
      BK_EXEC:  state_d = BK_ISSUE;
      default:  state_d = BK_ISSUE;
    endcase
  end

  // State outputs
  always_comb begin
    pop_o = 1'b0;
    exec  = 1'b0;
    unique case (state_q)
      BK_ISSUE: pop_o = !empty_i;
      BK_EXEC:  exec  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_ISSUE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= exec;
    end
  end

  // Capture the popped item
  always_ff @(posedge clk_i) begin
    if (pop_o) op_q <= head_i;
    if (exec)  rsp_q <= rsp_d;
  end

  // Select dot nibbles: address bit 1 clear picks the high byte
  always_comb begin
    dot_en    = op_q.a1 ? {2'b00, op_q.up, op_q.lo} : {op_q.up, op_q.lo, 2'b00};
    dot_wdata = op_q.a1 ? {8'h00, op_q.data[11:8], op_q.data[3:0]}
                        : {op_q.data[11:8], op_q.data[3:0], 8'h00};
  end

  // Form write enables and the result
  always_comb begin
    prog_be    = '0;
    word_ne    = '0;
    word_wdata = op_q.data;
    rsp_d.region          = op_q.region;
    rsp_d.forwarded       = op_q.fwd;
    rsp_d.forward_address = op_q.faddr;
    rsp_d.stalled         = op_q.stall;
    rsp_d.read_data       = op_q.data;
    if (op_q.wr) begin
      rsp_d.read_data = '0;
      unique case (op_q.mem)
        MEM_PROG: prog_be = {op_q.up, op_q.lo};
        MEM_WORD: begin
          if (op_q.dot) begin
            word_wdata = dot_wdata;
            for (int k = 0; k < 4; k++) begin
              unique case (op_q.prio)
                PRIO_NORMAL: word_ne[k] = dot_en[k];
                PRIO_UNDER:  word_ne[k] = dot_en[k] && (word_rdata_q[k*4 +: 4] == 4'h0);
                PRIO_OVER:   word_ne[k] = dot_en[k] && (dot_wdata[k*4 +: 4] != 4'h0);
                default:     word_ne[k] = 1'b0;
              endcase
            end
          end else begin
            word_ne = {op_q.up, op_q.up, op_q.lo, op_q.lo};
          end
        end
        default: ;
      endcase
    end else begin
      unique case (op_q.mem)
        MEM_PROG: rsp_d.read_data = prog_rdata_q;
        MEM_WORD: begin
          if (op_q.dot) begin
            rsp_d.read_data = op_q.a1 ? {4'h0, word_rdata_q[7:4], 4'h0, word_rdata_q[3:0]}
                                      : {4'h0, word_rdata_q[15:12], 4'h0, word_rdata_q[11:8]};
          end else begin
            rsp_d.read_data = word_rdata_q;
          end
        end
        default: ;
      endcase
    end
  end

  // Program RAM: byte-lane writes, registered read
  always_ff @(posedge clk_i) begin
    if (exec && prog_be[1]) prog_mem[op_q.idx[PROG_AW-1:0]][15:8] <= op_q.data[15:8];
    if (exec && prog_be[0]) prog_mem[op_q.idx[PROG_AW-1:0]][7:0]  <= op_q.data[7:0];
    if (pop_o) prog_rdata_q <= prog_mem[head_i.idx[PROG_AW-1:0]];
  end

  // Word RAM: nibble writes, registered read
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      if (exec && word_ne[k]) begin
        word_mem[op_q.idx[WRAM_AW-1:0]][k*4 +: 4] <= word_wdata[k*4 +: 4];
      end
    end
    if (pop_o) word_rdata_q <= word_mem[head_i.idx[WRAM_AW-1:0]];
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
`default_nettype wire

/* hdl/sub_bus_memory_map.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sub_bus_memory_map: sub-processor bus decoder with program and word RAM
// Top level: front-end decode, two-entry operation queue, memory back end.
// ----------------------------------------------------------------------------
// In the back end each item passes the issue state on the memory read port,
// then the exec state to form the result and write back (the dot window needs
// a read-modify-write of one word RAM word). A new item is popped only after
// the last is written back; an item passes the queue slot, the issue and exec
// states and the done register before done_o. The queue takes up to two more
// items while the back end works; busy is high while it is full. Results cannot
// be held off: done_o is high for one cycle only; rsp_o holds the last result.
// Memory contents are undefined after reset and must be written before they
// are read; there is no clearing pass. Memory sizes must be powers of two.
// ----------------------------------------------------------------------------
module sub_bus_memory_map #(
  parameter int unsigned PROGRAM_WORDS  = 262144,
  parameter int unsigned WORD_RAM_WORDS = 131072
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire sbmm_pkg::req_t                 req_i,
  output logic                                done_o,
  output sbmm_pkg::rsp_t                      rsp_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [sbmm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sbmm_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sbmm_pkg::*;

  op_t  dec_op;
  op_t  head_op;
  logic full;
  logic empty;
  logic pop;
  logic push;

  assign busy = full;
  assign push = start && !full;

  sbmm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_i),
    .op_o       (dec_op)
  );

  sbmm_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (dec_op),
    .pop_i     (pop),
    .head_o    (head_op),
    .full_o    (full),
    .empty_o   (empty)
  );

  sbmm_back #(
    .PROGRAM_WORDS  (PROGRAM_WORDS),
    .WORD_RAM_WORDS (WORD_RAM_WORDS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head_op),
    .empty_i (empty),
    .pop_o   (pop),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

endmodule
`default_nettype wire

/* hdl/sbmm_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sbmm_checker: port-level checks of the sub bus memory map
// Watches results on the top-level ports; bound to the top level below.
// ----------------------------------------------------------------------------
module sbmm_checker (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           done_o,
  input  wire sbmm_pkg::rsp_t rsp_o
);
  import sbmm_pkg::*;

  // Back end returns to issue after each exec, so strobes never touch
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobes in consecutive cycles");

  // An address reaches the outside only for a forwarded item
  a_faddr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.forwarded) |-> (rsp_o.forward_address == 24'h0))
    else $error("forward address without forwarding");

  // A refused access is a word RAM write that goes nowhere
  a_stall_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.stalled) |->
      (rsp_o.region == RG_WORD && rsp_o.read_data == 16'h0 && !rsp_o.forwarded))
    else $error("stall outside a refused word RAM write");

  // Unmapped items neither forward nor stall
  a_none_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.region == RG_NONE) |-> (!rsp_o.forwarded && !rsp_o.stalled))
    else $error("unmapped item forwarded or stalled");

endmodule

bind sub_bus_memory_map sbmm_checker u_sbmm_checker (.*);
`default_nettype wire
